[hdl/cpg_pkg.sv]
package cpg_pkg;

   localparam int COORD_BITS = 12;
   localparam int IN_COORD_BITS = 12;
   localparam int RADIUS_BITS = 11;
   localparam int OFF_BITS = 11;
   localparam int DEC_BITS = 16;
   localparam int PT_BITS = 14;
   localparam int POINTS_PER_STEP = 8;
   localparam int IDX_BITS = $clog2(POINTS_PER_STEP);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(POINTS_PER_STEP - 1);

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   localparam logic [DEC_BITS-1:0] DEC_INIT = DEC_BITS'(3);
   localparam logic [DEC_BITS-1:0] DEC_INC_LOW = DEC_BITS'(6);
   localparam logic [DEC_BITS-1:0] DEC_INC_HIGH = DEC_BITS'(10);

   typedef struct packed {
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      logic [OFF_BITS-1:0]   a;
      logic [OFF_BITS-1:0]   b;
      logic                  done;
   } cpg_job_type;

   function automatic logic [PT_BITS-1:0] coord_to_pt(input logic [COORD_BITS-1:0] c);
      logic [31:0] t;
      t = 32'(c);
      return t[PT_BITS-1:0];
   endfunction

endpackage

[hdl/cpg_req_if.sv]
interface cpg_req_if import cpg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [IN_COORD_BITS-1:0] center_x;
   logic [IN_COORD_BITS-1:0] center_y;
   logic [RADIUS_BITS-1:0]   radius;

   modport source (output valid, output req_type, output center_x, output center_y,
                   output radius, input ready);
   modport sink (input valid, input req_type, input center_x, input center_y,
                 input radius, output ready);
endinterface

[hdl/cpg_rsp_if.sv]
interface cpg_rsp_if import cpg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PT_BITS-1:0] point_x;
   logic [PT_BITS-1:0] point_y;
   logic               last_of_step;
   logic               circle_done;

   modport source (output valid, output point_x, output point_y, output last_of_step,
                   output circle_done, input ready);
   modport sink (input valid, input point_x, input point_y, input last_of_step,
                 input circle_done, output ready);
endinterface

[hdl/circle_point_generator.sv]
// Channel   Direction  Transaction
// req_chan  in         start (center, radius) or advance one octant step
// rsp_chan  out        one mirrored pixel with step-end and done flags
//
// A start transaction gives no pixels. An advance transaction, while a
// circle is active, gives eight pixels, one per cycle while rsp_chan.ready
// is high; the point emitter has a single result port. One step can wait
// in a holding slot while the previous one drains; req_chan stalls only
// while that slot is full. Reset is synchronous and returns the rasterizer
// to idle, clearing the core state and the emitter's valid flags and index.
module circle_point_generator import cpg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cpg_req_if.sink   req_chan,
   cpg_rsp_if.source rsp_chan
);

   cpg_job_type job;
   logic        job_valid;
   logic        job_ready;

   cpg_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .job_ready (job_ready),
      .job_valid (job_valid),
      .job       (job)
   );

   cpg_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

[hdl/cpg_core.sv]
module cpg_core import cpg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   cpg_req_if.sink      req_chan,
   input  logic         job_ready,
   output logic         job_valid,
   output cpg_job_type  job
);

   logic [COORD_BITS-1:0] cx_ff, cx_in;
   logic [COORD_BITS-1:0] cy_ff, cy_in;
   logic [OFF_BITS-1:0]   xo_ff, xo_in;
   logic [OFF_BITS-1:0]   yo_ff, yo_in;
   logic [DEC_BITS-1:0]   dec_ff, dec_in;
   logic                  active_ff, active_in;

   logic                  accept;
   logic                  dec_pos;
   logic [DEC_BITS-1:0]   a_ext;
   logic [DEC_BITS-1:0]   b_ext;
   logic [DEC_BITS-1:0]   dec_step;
   logic signed [OFF_BITS+1:0] a_next;
   logic signed [OFF_BITS+1:0] b_next;
   logic                  done;

   assign req_chan.ready = job_ready;
   assign accept = req_chan.valid && job_ready;

   always_comb begin
      a_ext = DEC_BITS'(xo_ff);
      b_ext = DEC_BITS'(yo_ff);
      dec_pos = !dec_ff[DEC_BITS-1] && (dec_ff != '0);
      a_next = $signed({2'b00, xo_ff}) + $signed((OFF_BITS+2)'(1));
      if (dec_pos) begin
         dec_step = dec_ff + ((a_ext - b_ext) << 2) + DEC_INC_HIGH;
         b_next = $signed({2'b00, yo_ff}) - $signed((OFF_BITS+2)'(1));
      end else begin
         dec_step = dec_ff + (a_ext << 2) + DEC_INC_LOW;
         b_next = $signed({2'b00, yo_ff});
      end
      done = a_next > b_next;

      cx_in = cx_ff;
      cy_in = cy_ff;
      xo_in = xo_ff;
      yo_in = yo_ff;
      dec_in = dec_ff;
      active_in = active_ff;
      job_valid = 1'b0;
      if (accept) begin
         if (req_chan.req_type == REQ_START) begin
            cx_in = COORD_BITS'(req_chan.center_x);
            cy_in = COORD_BITS'(req_chan.center_y);
            xo_in = '0;
            yo_in = OFF_BITS'(req_chan.radius);
            dec_in = DEC_INIT - (DEC_BITS'(req_chan.radius) << 1);
            active_in = 1'b1;
         end else if (active_ff) begin
            xo_in = a_next[OFF_BITS-1:0];
            yo_in = b_next[OFF_BITS-1:0];
            dec_in = dec_step;
            active_in = !done;
            job_valid = 1'b1;
         end
      end

      job.cx = cx_ff;
      job.cy = cy_ff;
      job.a = xo_ff;
      job.b = yo_ff;
      job.done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         xo_ff <= '0;
         yo_ff <= '0;
         dec_ff <= '0;
         active_ff <= 1'b0;
      end else begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         xo_ff <= xo_in;
         yo_ff <= yo_in;
         dec_ff <= dec_in;
         active_ff <= active_in;
      end
   end

endmodule

[hdl/cpg_emit.sv]
module cpg_emit import cpg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  cpg_job_type  job,
   output logic         job_ready,
   cpg_rsp_if.source    rsp_chan
);

   cpg_job_type           pend_ff, pend_in;
   logic                  pend_valid_ff, pend_valid_in;
   cpg_job_type           cur_ff, cur_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;

   logic                  fire;
   logic                  cur_free;
   logic [PT_BITS-1:0]    cx_pt;
   logic [PT_BITS-1:0]    cy_pt;
   logic [PT_BITS-1:0]    a_pt;
   logic [PT_BITS-1:0]    b_pt;
   logic [PT_BITS-1:0]    u_pt;
   logic [PT_BITS-1:0]    v_pt;

   assign job_ready = !pend_valid_ff;

   always_comb begin
      fire = cur_valid_ff && rsp_chan.ready;
      cur_free = !cur_valid_ff || (fire && idx_ff == LAST_IDX);

      pend_in = pend_ff;
      pend_valid_in = pend_valid_ff;
      cur_in = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in = fire ? idx_ff + IDX_BITS'(1) : idx_ff;

      if (cur_free) begin
         idx_in = '0;
         if (pend_valid_ff) begin
            cur_in = pend_ff;
            cur_valid_in = 1'b1;
            pend_valid_in = 1'b0;
         end else if (job_valid) begin
            cur_in = job;
            cur_valid_in = 1'b1;
         end else begin
            cur_valid_in = 1'b0;
         end
      end else if (job_valid) begin
         pend_in = job;
         pend_valid_in = 1'b1;
      end
   end

   always_comb begin
      cx_pt = coord_to_pt(cur_ff.cx);
      cy_pt = coord_to_pt(cur_ff.cy);
      a_pt = PT_BITS'(cur_ff.a);
      b_pt = PT_BITS'(cur_ff.b);
      if (idx_ff[IDX_BITS-1]) begin
         u_pt = b_pt;
         v_pt = a_pt;
      end else begin
         u_pt = a_pt;
         v_pt = b_pt;
      end
      rsp_chan.point_x = idx_ff[1] ? cx_pt - u_pt : cx_pt + u_pt;
      rsp_chan.point_y = idx_ff[0] ? cy_pt - v_pt : cy_pt + v_pt;
      rsp_chan.last_of_step = idx_ff == LAST_IDX;
      rsp_chan.circle_done = cur_ff.done;
      rsp_chan.valid = cur_valid_ff;
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      cur_ff <= cur_in;
      if (reset) begin
         pend_valid_ff <= 1'b0;
         cur_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         cur_valid_ff <= cur_valid_in;
         idx_ff <= idx_in;
      end
   end

endmodule
